@@ design/htfcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package htfcd_pkg;

    // Byte slots of one measurement frame
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_byte_pos;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // 1750 * 65535 fits in 27 bits, 1000 * 65535 in 26 bits
    localparam int TEMP_PROD_W = 27;
    localparam int HUMI_PROD_W = 26;

    localparam logic [10:0]            TEMP_SCALE  = 11'd1750;
    localparam logic [9:0]             HUMI_SCALE  = 10'd1000;
    // 450 * 65535
    localparam logic [TEMP_PROD_W-1:0] TEMP_OFFSET = 27'd29490750;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/humidity_temp_frame_crc_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sensor frame decoder with CRC-8 word check (poly 0x31, init 0xFF).
// Input channel (i_in_valid / o_in_ready): one frame byte per word, in the
// order temp high, temp low, temp CRC, humi high, humi low, humi CRC.
// i_frame_start marks a byte as the first of a frame and drops any partial
// frame. A word with a good CRC replaces the held raw value; a bad one keeps it.
// Output channel (o_out_valid / i_out_ready): one word per six input bytes,
// carrying both CRC flags, the held raw values, temperature in 0.1 degC and
// humidity in per-mille.
// Throughput: one input byte per cycle while o_in_ready is high. The CRC step
// is combinational on the accepted byte; conversion runs in a four-register
// pipeline (frame result, constant products, signed magnitude, divide by
// 65535 as add and shift).
// Reset: synchronous, active low; clears position, CRC and held raw values,
// empties the pipeline. o_in_ready is low during reset.
// Stall: each pipeline stage holds while the stage after it is full and
// blocked, so up to four results queue before o_in_ready drops.
module humidity_temp_frame_crc_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_start,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [11:0]      o_temperature_deci_c,
    output logic [9:0]              o_humidity_permille,
    output logic                    o_temp_crc_ok,
    output logic                    o_humi_crc_ok,
    output logic [15:0]             o_held_raw_temp,
    output logic [15:0]             o_held_raw_humi
);
    import htfcd_pkg::*;

    // Frame state
    t_byte_pos   r_pos,    n_pos;
    logic [7:0]  r_crc,    n_crc;
    logic [7:0]  r_hi,     n_hi;
    logic [7:0]  r_lo,     n_lo;
    logic        r_tgood,  n_tgood;
    logic [15:0] r_raw_t,  n_raw_t;
    logic [15:0] r_raw_h,  n_raw_h;

    t_byte_pos   w_pos;
    logic        w_accept;
    logic        w_emit;
    logic        w_match;
    logic [7:0]  w_crc_step;
    logic [7:0]  w_crc_first;

    // Pipeline enables: a stage loads when empty or when its content moves on
    logic en1, en2, en3, en4;

    // Stage 1: frame result
    logic        r_v1;
    logic        r_s1_tok, r_s1_hok;
    logic [15:0] r_s1_raw_t, r_s1_raw_h;

    // Stage 2: constant products
    logic                   r_v2;
    logic                   r_s2_tok, r_s2_hok;
    logic [15:0]            r_s2_raw_t, r_s2_raw_h;
    logic [TEMP_PROD_W-1:0] r_s2_prod_t;
    logic [HUMI_PROD_W-1:0] r_s2_prod_h;

    // Stage 3: temperature as sign and magnitude
    logic                   r_v3;
    logic                   r_s3_tok, r_s3_hok;
    logic [15:0]            r_s3_raw_t, r_s3_raw_h;
    logic [TEMP_PROD_W-1:0] r_s3_mag_t;
    logic                   r_s3_neg;
    logic [HUMI_PROD_W-1:0] r_s3_prod_h;

    logic                   w_ge;
    logic [TEMP_PROD_W-1:0] w_mag_t;

    // Stage 4: output register
    logic               r_v4;
    logic signed [11:0] r_out_temp;
    logic [9:0]         r_out_humi;
    logic               r_out_tok, r_out_hok;
    logic [15:0]        r_out_raw_t, r_out_raw_h;

    // x / 65535 == (x + (x >> 16) + 1) >> 16 for x < 65535 * 65536
    logic [TEMP_PROD_W:0] w_sum_t;
    logic [HUMI_PROD_W:0] w_sum_h;
    logic [11:0]          w_q_t;

    assign en4 = !r_v4 || i_out_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready = en1 && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;

    // A start mark forces slot 0; the unused codes also fall to slot 0
    assign w_pos       = i_frame_start ? POS_T_HI : r_pos;
    assign w_crc_step  = crc8_byte(r_crc, i_rx_byte);
    assign w_crc_first = crc8_byte(CRC_INIT, i_rx_byte);
    assign w_match     = (i_rx_byte == r_crc);

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_tgood = r_tgood;
        n_raw_t = r_raw_t;
        n_raw_h = r_raw_h;
        w_emit  = 1'b0;
        if (i_frame_start) begin
            n_tgood = 1'b0;
        end
        unique case (w_pos) inside
            POS_T_LO, POS_H_LO: begin
                n_lo  = i_rx_byte;
                n_crc = w_crc_step;
                n_pos = (w_pos == POS_T_LO) ? POS_T_CRC : POS_H_CRC;
            end
            POS_T_CRC: begin
                n_tgood = w_match;
                if (w_match) begin
                    n_raw_t = {r_hi, r_lo};
                end
                n_crc = CRC_INIT;
                n_pos = POS_H_HI;
            end
            POS_H_CRC: begin
                if (w_match) begin
                    n_raw_h = {r_hi, r_lo};
                end
                n_crc  = CRC_INIT;
                n_pos  = POS_T_HI;
                w_emit = 1'b1;
            end
            default: begin
                // high byte of either word: CRC restarts from the init value
                n_hi  = i_rx_byte;
                n_crc = w_crc_first;
                n_pos = (w_pos == POS_H_HI) ? POS_H_LO : POS_T_LO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_HI;
            r_crc   <= CRC_INIT;
            r_hi    <= 8'd0;
            r_lo    <= 8'd0;
            r_tgood <= 1'b0;
            r_raw_t <= 16'd0;
            r_raw_h <= 16'd0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_tgood <= n_tgood;
            r_raw_t <= n_raw_t;
            r_raw_h <= n_raw_h;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= w_accept && w_emit;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload stages
    assign w_ge    = (r_s2_prod_t >= TEMP_OFFSET);
    assign w_mag_t = w_ge ? (r_s2_prod_t - TEMP_OFFSET) : (TEMP_OFFSET - r_s2_prod_t);

    assign w_sum_t = {1'b0, r_s3_mag_t} + (TEMP_PROD_W+1)'(r_s3_mag_t[TEMP_PROD_W-1:16])
                     + (TEMP_PROD_W+1)'(1);
    assign w_sum_h = {1'b0, r_s3_prod_h} + (HUMI_PROD_W+1)'(r_s3_prod_h[HUMI_PROD_W-1:16])
                     + (HUMI_PROD_W+1)'(1);
    assign w_q_t   = w_sum_t[TEMP_PROD_W:16];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_tok   <= r_tgood;
            r_s1_hok   <= w_match;
            r_s1_raw_t <= n_raw_t;
            r_s1_raw_h <= n_raw_h;
        end
        if (en2) begin
            r_s2_tok    <= r_s1_tok;
            r_s2_hok    <= r_s1_hok;
            r_s2_raw_t  <= r_s1_raw_t;
            r_s2_raw_h  <= r_s1_raw_h;
            r_s2_prod_t <= TEMP_PROD_W'(r_s1_raw_t) * TEMP_PROD_W'(TEMP_SCALE);
            r_s2_prod_h <= HUMI_PROD_W'(r_s1_raw_h) * HUMI_PROD_W'(HUMI_SCALE);
        end
        if (en3) begin
            r_s3_tok    <= r_s2_tok;
            r_s3_hok    <= r_s2_hok;
            r_s3_raw_t  <= r_s2_raw_t;
            r_s3_raw_h  <= r_s2_raw_h;
            r_s3_mag_t  <= w_mag_t;
            r_s3_neg    <= !w_ge;
            r_s3_prod_h <= r_s2_prod_h;
        end
        if (en4) begin
            r_out_tok   <= r_s3_tok;
            r_out_hok   <= r_s3_hok;
            r_out_raw_t <= r_s3_raw_t;
            r_out_raw_h <= r_s3_raw_h;
            r_out_temp  <= r_s3_neg ? -$signed(w_q_t) : $signed(w_q_t);
            r_out_humi  <= w_sum_h[HUMI_PROD_W-1:16];
        end
    end

    assign o_out_valid          = r_v4;
    assign o_temperature_deci_c = r_out_temp;
    assign o_humidity_permille  = r_out_humi;
    assign o_temp_crc_ok        = r_out_tok;
    assign o_humi_crc_ok        = r_out_hok;
    assign o_held_raw_temp      = r_out_raw_t;
    assign o_held_raw_humi      = r_out_raw_h;

    // Checks
    a_emit_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_pos == POS_H_CRC) |=> r_v1)
        else $error("frame end did not load stage 1");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_start) |=> (r_pos == POS_T_LO && r_tgood == 1'b0))
        else $error("start mark did not restart the frame");

    a_humi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_humidity_permille <= 10'd1000))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature_deci_c >= -12'sd450 &&
                         o_temperature_deci_c <= 12'sd1300))
        else $error("temperature out of range");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en4) |=> r_v3)
        else $error("stage 3 dropped a result while stalled");

endmodule

`default_nettype wire

@@ tb/htfcd_frame_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the frame decoder, predicts each result word
// from the accepted input words and compares field by field.
module htfcd_frame_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_start,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [11:0] i_temperature_deci_c,
    input  wire logic [9:0]         i_humidity_permille,
    input  wire logic               i_temp_crc_ok,
    input  wire logic               i_humi_crc_ok,
    input  wire logic [15:0]        i_held_raw_temp,
    input  wire logic [15:0]        i_held_raw_humi,
    output int                      o_fail_count,
    output int                      o_pending
);
    import htfcd_pkg::*;

    typedef struct packed {
        logic signed [11:0] temp;
        logic [9:0]         humi;
        logic               t_ok;
        logic               h_ok;
        logic [15:0]        raw_t;
        logic [15:0]        raw_h;
    } t_frame_result;

    t_frame_result expected_frames[$];

    // predictor state
    logic [2:0]  slot;
    logic [7:0]  crc_acc;
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    logic        t_good;
    logic [15:0] held_t;
    logic [15:0] held_h;
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    // bit-serial form of the CRC-8 step, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // tenths of a degree, quotient truncated toward zero
    function automatic logic signed [11:0] temp_deci(input logic [15:0] raw);
        longint r;
        longint q;
        r = raw;
        q = (r * 1750 - 450 * 65535) / 65535;
        return q[11:0];
    endfunction

    function automatic logic [9:0] humi_permille(input logic [15:0] raw);
        longint r;
        longint q;
        r = raw;
        q = (r * 1000) / 65535;
        return q[9:0];
    endfunction

    function automatic void compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic fs);
        t_frame_result r;
        logic [2:0]    p;
        logic          ok;
        if (fs) begin
            slot   = POS_T_HI;
            t_good = 1'b0;
        end
        p    = (slot > POS_H_CRC) ? POS_T_HI : slot;
        slot = p + 3'd1;
        case (p)
            POS_T_HI, POS_H_HI: begin
                hi_byte = b;
                crc_acc = crc8_step(CRC_INIT, b);
            end
            POS_T_LO, POS_H_LO: begin
                lo_byte = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            POS_T_CRC: begin
                ok     = (b == crc_acc);
                t_good = ok;
                if (ok) held_t = {hi_byte, lo_byte};
                crc_acc = CRC_INIT;
            end
            default: begin
                ok = (b == crc_acc);
                if (ok) held_h = {hi_byte, lo_byte};
                crc_acc = CRC_INIT;
                slot    = POS_T_HI;
                r.temp  = temp_deci(held_t);
                r.humi  = humi_permille(held_h);
                r.t_ok  = t_good;
                r.h_ok  = ok;
                r.raw_t = held_t;
                r.raw_h = held_h;
                expected_frames.push_back(r);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        if (!i_rst_n) begin
            slot    = POS_T_HI;
            crc_acc = CRC_INIT;
            hi_byte = 8'h00;
            lo_byte = 8'h00;
            t_good  = 1'b0;
            held_t  = 16'h0000;
            held_h  = 16'h0000;
        end else begin
            if (i_in_valid && i_in_ready) take_byte(i_rx_byte, i_frame_start);
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result word with no frame pending");
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    compare_field("temperature_deci_c", $signed(want.temp),
                                  $signed(i_temperature_deci_c));
                    compare_field("humidity_permille", want.humi, i_humidity_permille);
                    compare_field("temp_crc_ok", want.t_ok, i_temp_crc_ok);
                    compare_field("humi_crc_ok", want.h_ok, i_humi_crc_ok);
                    compare_field("held_raw_temp", want.raw_t, i_held_raw_temp);
                    compare_field("held_raw_humi", want.raw_h, i_held_raw_humi);
                end
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

@@ tb/humidity_temp_frame_crc_decoder_tb.sv @@
`timescale 1ns / 1ps

// Top of the frame decoder bench: clock, reset, byte stimulus and the
// receiver's ready. All prediction and comparison lives in the checker.
module humidity_temp_frame_crc_decoder_tb;
    import htfcd_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_WORDS  = 250;
    localparam int HOLD_CYCLES  = 400;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte     = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic signed [11:0] temperature_deci_c;
    logic [9:0]         humidity_permille;
    logic               temp_crc_ok;
    logic               humi_crc_ok;
    logic [15:0]        held_raw_temp;
    logic [15:0]        held_raw_humi;

    int fail_count;
    int pending;

    // idle odds in percent, changed per phase by the stimulus
    int   snd_idle   = 35;
    int   rcv_idle   = 54;
    int   bytes_sent = 0;
    // one long receiver hold-off, requested by the stimulus
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;
    int   cycle_cnt  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    humidity_temp_frame_crc_decoder u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_rx_byte            (rx_byte),
        .i_frame_start        (frame_start),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_temperature_deci_c (temperature_deci_c),
        .o_humidity_permille  (humidity_permille),
        .o_temp_crc_ok        (temp_crc_ok),
        .o_humi_crc_ok        (humi_crc_ok),
        .o_held_raw_temp      (held_raw_temp),
        .o_held_raw_humi      (held_raw_humi)
    );

    htfcd_frame_checker u_chk (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_rx_byte            (rx_byte),
        .i_frame_start        (frame_start),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_temperature_deci_c (temperature_deci_c),
        .i_humidity_permille  (humidity_permille),
        .i_temp_crc_ok        (temp_crc_ok),
        .i_humi_crc_ok        (humi_crc_ok),
        .i_held_raw_temp      (held_raw_temp),
        .i_held_raw_humi      (held_raw_humi),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // Receiver: random ready, or held low for the whole hold-off stretch.
    // While held, the sender keeps offering bytes, so the pipeline fills
    // and in_ready has to drop.
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!rst_n || hold_left > 0) begin
            out_ready <= 1'b0;
            if (hold_left > 0) hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // CRC-8 over a whole 16-bit word, used to build frames with a good CRC
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] c;
        c = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            c = {c[6:0], 1'b0} ^ ((c[7] ^ w[i]) ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Raw words lean on the ends of the range and on the spot where the
    // temperature crosses zero (truncation toward zero shows just below it).
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd16851;
            3:       return 16'd16852;
            default: return 16'($urandom);
        endcase
    endfunction

    // One word on the input channel. Idle gaps come before the word; valid
    // then stays up with a fixed payload until accepted. in_ready is read
    // right after the edge, i.e. the value the edge itself saw.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // First n_bytes of a frame. A bad CRC is the good one with some bits
    // flipped, never zero flips.
    task automatic send_frame(input logic fs, input logic [15:0] tw, input logic t_ok,
                              input logic [15:0] hw, input logic h_ok, input int n_bytes);
        logic [7:0] fb[6];
        fb[0] = tw[15:8];
        fb[1] = tw[7:0];
        fb[2] = word_crc(tw) ^ (t_ok ? 8'h00 : 8'($urandom_range(1, 255)));
        fb[3] = hw[15:8];
        fb[4] = hw[7:0];
        fb[5] = word_crc(hw) ^ (h_ok ? 8'h00 : 8'($urandom_range(1, 255)));
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(fb[i], (i == 0) ? fs : 1'b0);
        end
    endtask

    // Mostly complete frames with random words and CRCs; some frames cut
    // short, and some loose noise bytes with an occasional start mark.
    task automatic random_sequence();
        int kind;
        kind = $urandom_range(99);
        if (kind < 75) begin
            send_frame(1'($urandom_range(1)), pick_word(), $urandom_range(99) < 75,
                       pick_word(), $urandom_range(99) < 75, 6);
        end else if (kind < 88) begin
            send_frame(1'b1, pick_word(), 1'b1, pick_word(), 1'b1, $urandom_range(1, 5));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        int phase_end;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames
        // lowest raw words: -45.0 degC, 0 per-mille
        send_frame(1'b1, 16'h0000, 1'b1, 16'h0000, 1'b1, 6);
        // no start mark, position wraps on its own; highest raw words
        send_frame(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 6);
        // temperature just under zero truncates to 0; bad humidity CRC keeps
        // the held humidity
        send_frame(1'b1, 16'd16851, 1'b1, 16'h1234, 1'b0, 6);
        // frame cut off inside the humidity word, then restarted
        send_frame(1'b1, 16'h1111, 1'b1, 16'h2222, 1'b1, 4);
        // bad temperature CRC, good humidity
        send_frame(1'b1, 16'hBEEF, 1'b0, 16'h8000, 1'b1, 6);

        // Random part in three idle phases; the last one also gets the
        // long receiver hold-off
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle = 35;
                    rcv_idle = 54;
                end
                1: begin
                    snd_idle = 54;
                    rcv_idle = 35;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                    hold_req = 1'b1;
                end
            endcase
            phase_end = bytes_sent + PHASE_WORDS;
            while (bytes_sent < phase_end) random_sequence();
        end
        in_valid <= 1'b0;

        // drain: let the checker see the last accept, then wait it out
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
